/* rtl/crcsu_pkg.sv */
`default_nettype none

package crcsu_pkg;

	localparam int BYTES_PER_ITEM = 8;
	localparam int DATA_SLOTS = 8;
	localparam int MAX_BYTES = (BYTES_PER_ITEM < DATA_SLOTS) ? BYTES_PER_ITEM : DATA_SLOTS;
	localparam int ROW_IDX_W = $clog2(DATA_SLOTS);
	localparam int COUNT_W = 4;

	localparam logic [31:0] POLY_RESET = 32'hEDB8_8320;
	localparam logic [7:0] ASCII_UPPER_A = 8'h41;
	localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
	localparam logic [7:0] ASCII_CASE_OFFSET = 8'h20;

	typedef logic [31:0] word_t;
	typedef logic [7:0] byte_t;
	typedef logic [COUNT_W-1:0] count_t;

	// One row holds the effect of each single set bit of a byte after a fixed
	// number of zero bytes has been shifted through the register.
	typedef logic [7:0][31:0] row_t;
	typedef row_t [DATA_SLOTS-1:0] basis_t;

	function automatic word_t shift_byte_zero(word_t poly, word_t x);
		word_t c;
		c = x;
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (c[0] ? poly : '0);
		end
		return c;
	endfunction

	function automatic row_t base_row(word_t poly);
		row_t r;
		for (int k = 0; k < 8; k++) begin
			r[k] = shift_byte_zero(poly, word_t'(1) << k);
		end
		return r;
	endfunction

	function automatic word_t apply_row(row_t row, byte_t b);
		word_t acc;
		acc = '0;
		for (int k = 0; k < 8; k++) begin
			if (b[k]) begin
				acc = acc ^ row[k];
			end
		end
		return acc;
	endfunction

	function automatic row_t next_row(row_t prev, row_t first);
		row_t r;
		for (int k = 0; k < 8; k++) begin
			r[k] = (prev[k] >> 8) ^ apply_row(first, prev[k][7:0]);
		end
		return r;
	endfunction

	function automatic byte_t fold_byte(byte_t b);
		byte_t r;
		r = b;
		if (b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z) begin
			r = b + ASCII_CASE_OFFSET;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/crcsu_lane.sv */
`default_nettype none

module crcsu_lane
	import crcsu_pkg::*;
(
	input  row_t  row,
	input  byte_t data_byte,
	output word_t term
);

	assign term = apply_row(row, data_byte);

endmodule

`default_nettype wire

/* rtl/crcsu_basis.sv */
`default_nettype none

module crcsu_basis
	import crcsu_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   poly_write,
	input  word_t  poly_data,
	output basis_t rows,
	output logic   busy
);

	localparam logic [ROW_IDX_W-1:0] LAST_ROW = ROW_IDX_W'(DATA_SLOTS - 1);

	word_t                poly_q;
	logic                 busy_q;
	logic [ROW_IDX_W-1:0] cnt_q;
	basis_t               rows_q;
	row_t                 prev_q;
	row_t                 new_row;

	always_comb begin
		if (cnt_q == '0) begin
			new_row = base_row(poly_q);
		end else begin
			new_row = next_row(prev_q, rows_q[0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= POLY_RESET;
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (poly_write) begin
			poly_q <= poly_data;
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST_ROW) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && !poly_write) begin
			rows_q[cnt_q] <= new_row;
			prev_q        <= new_row;
		end
	end

	assign rows = rows_q;
	assign busy = busy_q;

endmodule

`default_nettype wire

/* rtl/crc32_stream_update.sv */
// Running reflected CRC-32 over a byte stream, up to eight bytes per transaction.
// Input channel: in_valid/in_stall with data_bytes, byte_count, start_req, seed
// and fold_case. A transaction is taken at a clock edge with in_valid high and
// in_stall low. Byte 0 sits in data_bytes[7:0]; counts above eight saturate.
// Output channel: out_valid/out_stall with crc, one result per input transaction.
// The result is registered in the first stage and then in the output register
// before it shows on out_valid; one transaction per cycle is accepted and
// delivered in steady state while out_stall stays low. The feedback stage closes
// the loop on the running CRC through eight table lanes and one XOR merge.
// Writing cfg_data with cfg_write high sets the reflected polynomial; the user
// must write it only while the block is idle, which the block does not enforce.
// After reset, and after each polynomial write, the block builds its per-byte
// tables and holds in_stall high meanwhile. Reset sets
// the polynomial to the standard CRC-32 value and the running CRC to zero.
// When out_stall is high the result holds; one more transaction can be taken
// into the first stage, after which in_stall rises.
`default_nettype none

module crc32_stream_update
	import crcsu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] data_bytes,
	input  logic [3:0]  byte_count,
	input  logic        start_req,
	input  logic [31:0] seed,
	input  logic        fold_case,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] crc
);

	basis_t rows;
	logic   busy;

	crcsu_basis u_basis (
		.clk        (clk),
		.arst_n     (arst_n),
		.poly_write (cfg_write),
		.poly_data  (cfg_data),
		.rows       (rows),
		.busy       (busy)
	);

	count_t      n_bytes;
	count_t      shamt;
	logic [63:0] masked;
	logic [63:0] aligned;
	word_t       dterm [DATA_SLOTS];
	word_t       dsum;

	logic        valid_s1;
	word_t       dsum_s1;
	count_t      shamt_s1;
	logic        start_s1;
	word_t       seed_s1;
	logic        out_valid_q;
	word_t       crc_q;

	word_t       crc_in;
	logic [95:0] crc_wide;
	word_t       cterm [DATA_SLOTS];
	word_t       result;
	logic        adv2;
	logic        take1;

	always_comb begin
		if (byte_count > COUNT_W'(MAX_BYTES)) begin
			n_bytes = COUNT_W'(MAX_BYTES);
		end else begin
			n_bytes = byte_count;
		end
		shamt = COUNT_W'(DATA_SLOTS) - n_bytes;
	end

	always_comb begin
		byte_t b;
		for (int i = 0; i < DATA_SLOTS; i++) begin
			b = data_bytes[8*i +: 8];
			if (fold_case) begin
				b = fold_byte(b);
			end
			masked[8*i +: 8] = (COUNT_W'(i) < n_bytes) ? b : '0;
		end
		aligned = masked << {shamt, 3'b000};
	end

	for (genvar j = 0; j < DATA_SLOTS; j++) begin : g_data_lane
		crcsu_lane u_lane (
			.row       (rows[DATA_SLOTS-1-j]),
			.data_byte (aligned[8*j +: 8]),
			.term      (dterm[j])
		);
	end

	always_comb begin
		dsum = '0;
		for (int j = 0; j < DATA_SLOTS; j++) begin
			dsum = dsum ^ dterm[j];
		end
	end

	assign adv2     = !out_valid_q || !out_stall;
	assign in_stall = busy || (valid_s1 && !adv2);
	assign take1    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take1) begin
			valid_s1 <= 1'b1;
		end else if (adv2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take1) begin
			dsum_s1  <= dsum;
			shamt_s1 <= shamt;
			start_s1 <= start_req;
			seed_s1  <= seed;
		end
	end

	assign crc_in   = start_s1 ? seed_s1 : crc_q;
	assign crc_wide = {64'b0, crc_in} << {shamt_s1, 3'b000};

	for (genvar j = 0; j < DATA_SLOTS; j++) begin : g_crc_lane
		crcsu_lane u_lane (
			.row       (rows[DATA_SLOTS-1-j]),
			.data_byte (crc_wide[8*j +: 8]),
			.term      (cterm[j])
		);
	end

	always_comb begin
		result = crc_wide[95:64] ^ dsum_s1;
		for (int j = 0; j < DATA_SLOTS; j++) begin
			result = result ^ cterm[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			crc_q       <= '0;
		end else if (adv2) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				crc_q <= result;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign crc       = crc_q;

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> in_stall)
		else $error("input taken while tables are being built");

	a_no_busy_with_work: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy && valid_s1))
		else $error("table build overlaps a transaction in flight");

	a_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv2) |=> out_valid)
		else $error("first stage advanced without producing a result");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv2) |=> valid_s1)
		else $error("stalled transaction lost from first stage");

endmodule

`default_nettype wire

/* tb/crc32_stream_update_checker.sv */
module crc32_stream_update_checker
	import crcsu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [63:0] data_bytes,
	input  logic [3:0]  byte_count,
	input  logic        start_req,
	input  logic [31:0] seed,
	input  logic        fold_case,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] crc,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	word_t poly_q;
	word_t running_q;
	word_t next_crc;
	word_t want_crc;
	word_t expected_crcs[$];

	function automatic word_t crc_after_bytes(word_t poly, word_t start_crc,
			logic [63:0] data, count_t cnt, logic fold);
		word_t c;
		byte_t b;
		int n;
		c = start_crc;
		n = (int'(cnt) > MAX_BYTES) ? MAX_BYTES : int'(cnt);
		for (int i = 0; i < n; i++) begin
			b = data[8*i +: 8];
			if (fold && b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z) begin
				b = b + ASCII_CASE_OFFSET;
			end
			c = c ^ {24'h0, b};
			for (int k = 0; k < 8; k++) begin
				c = (c >> 1) ^ (c[0] ? poly : 32'h0);
			end
		end
		return c;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= POLY_RESET;
			running_q <= '0;
			expected_crcs.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_write) begin
				poly_q <= cfg_data;
			end
			if (out_valid && !out_stall) begin
				if (expected_crcs.size() == 0) begin
					$display("%0t: result with no transaction pending, expected none, actual %08h",
						$time, crc);
					errors++;
				end else begin
					want_crc = expected_crcs.pop_front();
					if (crc !== want_crc) begin
						$display("%0t: crc mismatch, expected %08h, actual %08h",
							$time, want_crc, crc);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				next_crc = crc_after_bytes(poly_q, start_req ? seed : running_q,
					data_bytes, byte_count, fold_case);
				running_q <= next_crc;
				expected_crcs.push_back(next_crc);
			end
			pending = expected_crcs.size();
		end
	end

endmodule

/* tb/crc32_stream_update_tb.sv */
module crc32_stream_update_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import crcsu_pkg::*;

	localparam int LONG_HOLD = 64;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [63:0] data_bytes = '0;
	logic [3:0]  byte_count = '0;
	logic        start_req = 1'b0;
	logic [31:0] seed = '0;
	logic        fold_case = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] crc;

	int errors;
	int pending;
	logic quiet = 1'b0;
	logic hold_long = 1'b0;

	crc32_stream_update dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_bytes(data_bytes),
		.byte_count(byte_count),
		.start_req(start_req),
		.seed(seed),
		.fold_case(fold_case),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.crc(crc)
	);

	crc32_stream_update_checker crc_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_bytes(data_bytes),
		.byte_count(byte_count),
		.start_req(start_req),
		.seed(seed),
		.fold_case(fold_case),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.crc(crc),
		.errors(errors),
		.pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always begin
		@(posedge clk);
		if (hold_long) begin
			out_stall <= 1'b1;
			repeat (LONG_HOLD) @(posedge clk);
			out_stall <= 1'b0;
			hold_long = 1'b0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			out_stall <= 1'b1;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			out_stall <= 1'b0;
		end
	end

	task automatic send_item(input logic [63:0] d, input count_t n, input logic st,
			input word_t sd, input logic fc);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_bytes <= d;
		byte_count <= n;
		start_req <= st;
		seed <= sd;
		fold_case <= fc;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	task automatic write_poly(input word_t value);
		drain_results();
		cfg_write <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	function automatic logic [63:0] pick_bytes();
		logic [63:0] d;
		if ($urandom_range(0, 2) == 0) begin
			d = {$urandom, $urandom};
		end else begin
			for (int i = 0; i < 8; i++) begin
				d[8*i +: 8] = 8'($urandom_range(8'h3F, 8'h7C));
			end
		end
		return d;
	endfunction

	function automatic count_t pick_count();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) begin
			return count_t'(0);
		end else if (r == 1) begin
			return count_t'($urandom_range(9, 15));
		end else if (r < 8) begin
			return count_t'(8);
		end
		return count_t'($urandom_range(1, 8));
	endfunction

	function automatic word_t pick_seed();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0) begin
			return 32'h0000_0000;
		end else if (r == 1) begin
			return 32'hFFFF_FFFF;
		end
		return word_t'($urandom);
	endfunction

	// Mostly whole messages: a seeded first transaction followed by a run
	// of continuation transactions, with the odd stray restart mixed in.
	task automatic run_messages(input int total);
		int left;
		logic st;
		left = 0;
		for (int i = 0; i < total; i++) begin
			if (left == 0) begin
				st = 1'b1;
				left = $urandom_range(1, 12);
			end else begin
				st = ($urandom_range(0, 39) == 0);
			end
			left--;
			send_item(pick_bytes(), pick_count(), st, pick_seed(), 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		send_item(64'h3837_3635_3433_3231, 4'd8, 1'b1, 32'hFFFF_FFFF, 1'b0);
		send_item(64'h0000_0000_0000_0039, 4'd1, 1'b0, 32'h0000_0000, 1'b0);
		send_item(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 32'h0000_0000, 1'b0);
		send_item(64'h0000_0000_0000_0000, 4'd8, 1'b0, 32'hFFFF_FFFF, 1'b1);
		send_item(64'h0123_4567_89AB_CDEF, 4'd0, 1'b1, 32'hDEAD_BEEF, 1'b0);
		send_item(64'hFEDC_BA98_7654_3210, 4'd0, 1'b0, 32'h1234_5678, 1'b1);
		send_item(64'hA5A5_5A5A_C3C3_3C3C, 4'd15, 1'b0, 32'h0000_0000, 1'b0);
		send_item(64'h5A5A_A5A5_3C3C_C3C3, 4'd9, 1'b1, 32'h8000_0001, 1'b0);
		send_item(64'h7B7A_6160_5B5A_4140, 4'd8, 1'b1, 32'h0000_0000, 1'b1);
		send_item(64'h7B7A_6160_5B5A_4140, 4'd8, 1'b1, 32'h0000_0000, 1'b0);
		send_item(64'h4142_4344_5A59_5857, 4'd8, 1'b0, 32'h0000_0000, 1'b1);
		for (int n = 1; n < 8; n++) begin
			send_item(64'h4C4B_4A49_4847_4645, count_t'(n), 1'b0, 32'hFFFF_FFFF, 1'b1);
		end
		send_item(64'h8000_0000_0000_0001, 4'd8, 1'b1, 32'hFFFF_FFFF, 1'b0);
		send_item(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0, 32'h0000_0000, 1'b1);

		run_messages(330);
		write_poly(32'h0000_0000);
		run_messages(300);
		write_poly(32'hFFFF_FFFF);
		run_messages(150);
		hold_long = 1'b1;
		run_messages(150);
		write_poly(32'h82F6_3B78);
		run_messages(300);
		write_poly(word_t'($urandom));
		run_messages(300);
		write_poly(POLY_RESET);
		run_messages(200);
		quiet = 1'b1;
		run_messages(180);

		drain_results();
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
